// ----- design/pidl_pkg.sv -----
`default_nettype none

package pidl_pkg;

    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 11;
    localparam int SETPT_W    = 10;
    localparam int GAIN_W     = 32;
    localparam int DUTY_W     = 8;
    localparam int ERR_W      = LEVEL_W + 1;   // setpoint minus level, signed
    localparam int DE_W       = ERR_W + 1;     // error change, signed
    localparam int MAG_W      = 12;            // |error| and |error change| both fit
    localparam int MUL_W      = 32;            // shared multiplier operand width
    localparam int PROD_W     = TIME_W + MAG_W;

    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int INTEG_WIDTH_DEF    = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd3;

    localparam logic [SETPT_W-1:0] SETPOINT_RST = 10'd10;
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 32'd1006632960;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 32'd33554;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 32'd1677722;

    localparam logic [DUTY_W-1:0] DUTY_MIN = 8'd50;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd250;

endpackage

`default_nettype wire

// ----- design/pid_level_controller_top.sv -----
// PID level controller: water level samples in, pump PWM duty out.
// Input channel (s_valid/s_ready): one sample per transfer, a millisecond
// timestamp and a signed level in cm. Output channel (m_valid/m_ready): one
// duty value (50..250) per sample, in sample order.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 setpoint, 1 kp, 2 ki, 3 kd) at the clock edge; write only while idle.
// Timing: s_ready is high only while the sequencer is idle. After an input
// transfer the sequencer runs PROD, INTEG, KD, KP, KI_LO, KI_HI, KI_ADD,
// DIV_WAIT and CLAMP. DIV_WAIT waits for the 44-step restoring divider for
// the derivative term, unless the timestamp equals the previous one (no
// derivative division); the other products go through one shared 32x32
// multiplier in turn. s_ready rises again together with m_valid, so a new
// sample is taken only once the previous result is in the output register.
// Stall: the result sits in an output register; a new sample can be taken
// while it waits. If a second result is ready before the first is taken, the
// sequencer holds it and stays busy until m_ready frees the output.
// Reset (aresetn low, synchronous): registers return to their default values,
// integral, previous error and previous timestamp clear, output empties.
`default_nettype none

module pid_level_controller_top
    import pidl_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int INTEG_WIDTH    = INTEG_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [TIME_W-1:0]          s_now_ms,
    input  wire logic signed [LEVEL_W-1:0]  s_level_cm,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [DUTY_W-1:0]               m_pwm_duty
);

    localparam int SUMI_W = ((INTEG_WIDTH > PROD_W) ? INTEG_WIDTH : PROD_W) + 2;
    localparam int ACC_W  = GAIN_W + INTEG_WIDTH + 2;
    localparam int INT_W  = ACC_W - GAIN_FRAC_BITS;
    localparam logic signed [SUMI_W-1:0] IMAX_EXT =
        $signed({{(SUMI_W-INTEG_WIDTH+1){1'b0}}, {(INTEG_WIDTH-1){1'b1}}});
    localparam logic signed [SUMI_W-1:0] IMIN_EXT =
        $signed({{(SUMI_W-INTEG_WIDTH+1){1'b1}}, {(INTEG_WIDTH-1){1'b0}}});

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_PROD     = 10'b0000000010,
        S_INTEG    = 10'b0000000100,
        S_KD       = 10'b0000001000,
        S_KP       = 10'b0000010000,
        S_KI_LO    = 10'b0000100000,
        S_KI_HI    = 10'b0001000000,
        S_KI_ADD   = 10'b0010000000,
        S_DIV_WAIT = 10'b0100000000,
        S_CLAMP    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SETPT_W-1:0] setpoint_reg;
    logic [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;

    logic [TIME_W-1:0]             prev_time_reg, dt_reg;
    logic signed [ERR_W-1:0]       err_reg, prev_err_reg;
    logic [MAG_W-1:0]              de_mag_reg;
    logic                          de_neg_reg;
    logic signed [INTEG_WIDTH-1:0] integral_reg, integral_next;
    logic [INTEG_WIDTH-1:0]        mag_reg;
    logic                          integ_neg_reg;
    logic [2*MUL_W-1:0]            prod_reg, prod_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic                          m_valid_reg;
    logic [DUTY_W-1:0]             m_pwm_duty_reg;

    logic                     err_neg;
    logic [MAG_W-1:0]         err_mag;
    logic signed [DE_W-1:0]   de_val, de_abs;
    logic [2*MUL_W-1:0]       mag_wide;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic signed [SUMI_W-1:0] integ_ext, prod_ext, isum;
    logic [ACC_W-1:0]         addend;
    logic                     add_neg;
    logic                     dt_zero;
    logic [INT_W-1:0]         int_part;
    logic [DUTY_W-1:0]        duty;
    logic                     out_free;
    logic                     div_start, div_done;
    logic [PROD_W-1:0]        div_quot;

    assign dt_zero  = (dt_reg == '0);
    assign err_neg  = err_reg[ERR_W-1];
    assign err_mag  = err_neg ? MAG_W'(-err_reg) : MAG_W'(err_reg);
    assign de_val   = {err_reg[ERR_W-1], err_reg} - {prev_err_reg[ERR_W-1], prev_err_reg};
    assign de_abs   = de_val[DE_W-1] ? -de_val : de_val;
    assign mag_wide = (2*MUL_W)'(mag_reg);
    assign out_free = !m_valid_reg || m_ready;

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PROD:  begin mul_a = dt_reg; mul_b = MUL_W'(err_mag);    end
            S_KD:    begin mul_a = kd_reg; mul_b = MUL_W'(de_mag_reg); end
            S_KP:    begin mul_a = kp_reg; mul_b = MUL_W'(err_mag);    end
            S_KI_LO: begin mul_a = ki_reg; mul_b = mag_wide[MUL_W-1:0];       end
            S_KI_HI: begin mul_a = ki_reg; mul_b = mag_wide[2*MUL_W-1:MUL_W]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod_next = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
    end

    // saturating integral update
    always_comb begin
        integ_ext = SUMI_W'(integral_reg);
        prod_ext  = $signed(SUMI_W'(prod_reg[PROD_W-1:0]));
        isum      = err_neg ? (integ_ext - prod_ext) : (integ_ext + prod_ext);
        if (isum > IMAX_EXT) begin
            integral_next = IMAX_EXT[INTEG_WIDTH-1:0];
        end else if (isum < IMIN_EXT) begin
            integral_next = IMIN_EXT[INTEG_WIDTH-1:0];
        end else begin
            integral_next = isum[INTEG_WIDTH-1:0];
        end
    end

    // accumulator for kp*e + ki*integral + d
    always_comb begin
        addend  = '0;
        add_neg = 1'b0;
        case (state_reg)
            S_KI_LO: begin
                addend  = ACC_W'(prod_reg);
                add_neg = err_neg;
            end
            S_KI_HI: begin
                addend  = ACC_W'(prod_reg);
                add_neg = integ_neg_reg;
            end
            S_KI_ADD: begin
                addend  = ACC_W'({prod_reg, {MUL_W{1'b0}}});
                add_neg = integ_neg_reg;
            end
            S_DIV_WAIT: begin
                addend  = dt_zero ? '0 : ACC_W'(div_quot);
                add_neg = de_neg_reg;
            end
            default: begin
                addend  = '0;
                add_neg = 1'b0;
            end
        endcase
        acc_next = add_neg ? (acc_reg - addend) : (acc_reg + addend);
    end

    // drop fraction, clamp to duty range
    always_comb begin
        int_part = acc_reg[ACC_W-1:GAIN_FRAC_BITS];
        if (acc_reg[ACC_W-1]) begin
            duty = DUTY_MIN;
        end else if (int_part > INT_W'(DUTY_MAX)) begin
            duty = DUTY_MAX;
        end else if (int_part < INT_W'(DUTY_MIN)) begin
            duty = DUTY_MIN;
        end else begin
            duty = int_part[DUTY_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (s_valid) state_next = S_PROD;
            S_PROD:     state_next = S_INTEG;
            S_INTEG:    state_next = S_KD;
            S_KD:       state_next = S_KP;
            S_KP:       state_next = S_KI_LO;
            S_KI_LO:    state_next = S_KI_HI;
            S_KI_HI:    state_next = S_KI_ADD;
            S_KI_ADD:   state_next = S_DIV_WAIT;
            S_DIV_WAIT: if (dt_zero || div_done) state_next = S_CLAMP;
            S_CLAMP:    if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    assign div_start = (state_reg == S_KP) && !dt_zero;

    pidl_div #(
        .NUM_W (PROD_W),
        .DEN_W (TIME_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg[PROD_W-1:0]),
        .den     (dt_reg),
        .quot    (div_quot),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            setpoint_reg  <= SETPOINT_RST;
            kp_reg        <= PROP_GAIN_RST;
            ki_reg        <= INTEG_GAIN_RST;
            kd_reg        <= DERIV_GAIN_RST;
            prev_time_reg <= '0;
            prev_err_reg  <= '0;
            integral_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SETPOINT:   setpoint_reg <= cfg_wdata[SETPT_W-1:0];
                    REG_PROP_GAIN:  kp_reg       <= cfg_wdata[GAIN_W-1:0];
                    REG_INTEG_GAIN: ki_reg       <= cfg_wdata[GAIN_W-1:0];
                    REG_DERIV_GAIN: kd_reg       <= cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_IDLE && s_valid) begin
                prev_time_reg <= s_now_ms;
            end
            if (state_reg == S_PROD) begin
                prev_err_reg <= err_reg;
            end
            if (state_reg == S_INTEG) begin
                integral_reg <= integral_next;
            end
            if (state_reg == S_CLAMP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            dt_reg  <= s_now_ms - prev_time_reg;
            err_reg <= $signed({{(ERR_W-SETPT_W){1'b0}}, setpoint_reg})
                     - $signed({s_level_cm[LEVEL_W-1], s_level_cm});
        end
        if (state_reg == S_PROD) begin
            de_mag_reg <= de_abs[MAG_W-1:0];
            de_neg_reg <= de_val[DE_W-1];
        end
        if (state_reg == S_KD) begin
            integ_neg_reg <= integral_reg[INTEG_WIDTH-1];
            mag_reg       <= integral_reg[INTEG_WIDTH-1]
                           ? (~integral_reg + INTEG_WIDTH'(1)) : integral_reg;
        end
        case (state_reg)
            S_PROD, S_KD, S_KP, S_KI_LO, S_KI_HI: prod_reg <= prod_next;
            default: ;
        endcase
        if (state_reg == S_KP) begin
            acc_reg <= '0;
        end else if (state_reg == S_KI_LO || state_reg == S_KI_HI ||
                     state_reg == S_KI_ADD ||
                     (state_reg == S_DIV_WAIT && (dt_zero || div_done))) begin
            acc_reg <= acc_next;
        end
        if (state_reg == S_CLAMP && out_free) begin
            m_pwm_duty_reg <= duty;
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_pwm_duty = m_pwm_duty_reg;

endmodule

`default_nettype wire

// ----- design/pidl_div.sv -----
`default_nettype none

module pidl_div
    import pidl_pkg::*;
#(
    parameter int NUM_W = PROD_W,
    parameter int DEN_W = TIME_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quot,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   rem_next;

    // restoring division, one quotient bit per cycle; numerator shifts out as quotient shifts in
    always_comb begin
        trial    = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign quot = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- design/pidl_checker.sv -----
`default_nettype none

module pidl_checker
    import pidl_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [DUTY_W-1:0] m_pwm_duty
);

    // a pending result is not dropped
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pwm_duty >= DUTY_MIN) && (m_pwm_duty <= DUTY_MAX))
        else $error("duty out of clamp range");

    // sequencer stays busy after taking a sample
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken again too early");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not idle after reset");

endmodule

bind pid_level_controller_top pidl_checker u_pidl_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_pwm_duty (m_pwm_duty)
);

`default_nettype wire

// ----- test/pid_level_controller_top_tb.sv -----
`timescale 1ns / 100ps

module pid_level_controller_top_tb;
    import pidl_pkg::*;

    localparam int   RX_HOLD_CYCLES = 800;
    localparam int   INTEG_MAX_MAG  = 500;   // |error| used when steering the integral
    localparam logic [TIME_W-1:0] DT_MAX = '1;

    logic                        aclk;
    logic                        aresetn    = 1'b0;
    logic                        cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index  = REG_SETPOINT;
    logic [CFG_DATA_W-1:0]       cfg_wdata  = '0;
    logic                        s_valid    = 1'b0;
    logic                        s_ready;
    logic [TIME_W-1:0]           s_now_ms   = '0;
    logic signed [LEVEL_W-1:0]   s_level_cm = '0;
    logic                        m_valid;
    logic                        m_ready    = 1'b0;
    logic [DUTY_W-1:0]           m_pwm_duty;

    // controller image: registers and state
    logic [SETPT_W-1:0] reg_setpoint  = SETPOINT_RST;
    logic [GAIN_W-1:0]  reg_kp        = PROP_GAIN_RST;
    logic [GAIN_W-1:0]  reg_ki        = INTEG_GAIN_RST;
    logic [GAIN_W-1:0]  reg_kd        = DERIV_GAIN_RST;
    longint             pid_integral  = 0;
    longint             pid_prev_err  = 0;
    logic [TIME_W-1:0]  pid_prev_time = '0;

    logic [DUTY_W-1:0]  expected_duty[$];
    int                 n_errors      = 0;

    // sender / receiver behavior knobs
    bit                 tx_gaps_on    = 1'b0;
    int                 tx_gap_max    = 1;
    int                 tx_burst_left = 0;
    int                 rx_stall_pct  = 0;
    bit                 rx_hold_go    = 1'b0;

    pid_level_controller_top i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_now_ms   (s_now_ms),
        .s_level_cm (s_level_cm),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pwm_duty (m_pwm_duty)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Advances the controller image by one sample, returns the duty it yields.
    function automatic logic [DUTY_W-1:0] predict_duty(input logic [TIME_W-1:0] now,
                                                       input logic signed [LEVEL_W-1:0] level);
        longint                imax;
        longint                imin;
        longint                err;
        longint                prod;
        longint                dterm;
        logic [TIME_W-1:0]     dt;
        logic signed [127:0]   ki_op;
        logic signed [127:0]   integ_op;
        logic signed [127:0]   kp_op;
        logic signed [127:0]   d_op;
        logic signed [127:0]   acc;
        logic signed [127:0]   ipart;
        logic [DUTY_W-1:0]     duty;
        imax = (longint'(1) <<< (INTEG_WIDTH_DEF - 1)) - 1;
        imin = -imax - 1;
        dt   = now - pid_prev_time;
        err  = longint'(reg_setpoint) - longint'(level);
        prod = err * longint'(dt);
        if (prod > 0 && pid_integral > imax - prod) begin
            pid_integral = imax;
        end else if (prod < 0 && pid_integral < imin - prod) begin
            pid_integral = imin;
        end else begin
            pid_integral = pid_integral + prod;
        end
        dterm = 0;
        if (dt != '0) begin
            dterm = (longint'(reg_kd) * (err - pid_prev_err)) / longint'(dt);
        end
        ki_op    = {96'd0, reg_ki};
        integ_op = 128'(pid_integral);
        kp_op    = 128'(longint'(reg_kp) * err);
        d_op     = 128'(dterm);
        acc      = ki_op * integ_op + kp_op + d_op;
        ipart    = acc >>> GAIN_FRAC_BITS_DEF;
        if (acc < 0) begin
            duty = DUTY_MIN;
        end else if (ipart > 128'sd250) begin
            duty = DUTY_MAX;
        end else if (ipart < 128'sd50) begin
            duty = DUTY_MIN;
        end else begin
            duty = ipart[DUTY_W-1:0];
        end
        pid_prev_err  = err;
        pid_prev_time = now;
        return duty;
    endfunction

    // Offers one sample and returns at the edge where it is transferred.
    task automatic send_sample(input logic [TIME_W-1:0] now,
                               input logic signed [LEVEL_W-1:0] level);
        bit taken;
        if (tx_gaps_on && tx_burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, tx_gap_max)) @(posedge aclk);
            tx_burst_left = $urandom_range(1, 10);
        end
        if (tx_burst_left > 0) tx_burst_left--;
        s_valid    <= 1'b1;
        s_now_ms   <= now;
        s_level_cm <= level;
        do begin
            @(negedge aclk);
            taken = s_ready;
            if (taken) expected_duty.push_back(predict_duty(now, level));
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (expected_duty.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SETPOINT:   reg_setpoint = data[SETPT_W-1:0];
            REG_PROP_GAIN:  reg_kp       = data;
            REG_INTEG_GAIN: reg_ki       = data;
            REG_DERIV_GAIN: reg_kd       = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] sp, input logic [GAIN_W-1:0] kp,
                             input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
    endtask

    // Drives the integral toward target with setpoint 512 and error +/-500.
    // Block must be idle on entry.
    task automatic steer_integral(input longint target);
        longint            diff;
        longint            mag;
        logic [TIME_W-1:0] step;
        write_reg(REG_SETPOINT, 32'd512);
        diff = target - pid_integral;
        while (diff >= INTEG_MAX_MAG || diff <= -INTEG_MAX_MAG) begin
            mag = (diff < 0) ? -diff : diff;
            mag = mag / INTEG_MAX_MAG;
            if (mag > longint'(DT_MAX)) mag = longint'(DT_MAX);
            step = mag[TIME_W-1:0];
            send_sample(pid_prev_time + step, (diff > 0) ? 11'sd12 : 11'sd1012);
            diff = target - pid_integral;
        end
    endtask

    task automatic test_first_sample();
        tx_gaps_on   = 1'b0;
        rx_stall_pct = 0;
        // elapsed time of the first sample counts from timestamp zero
        send_sample(32'd250, 11'sd9);
        send_sample(32'd250, 11'sd10);
        send_sample(32'd260, 11'sd4);
        wait_results_done();
    endtask

    task automatic test_field_extremes();
        tx_gaps_on   = 1'b1;
        tx_gap_max   = 60;
        rx_stall_pct = 30;
        send_sample(32'd1000, -11'sd1024);
        send_sample(32'd1000, 11'sd1023);          // zero elapsed
        send_sample(32'hFFFF_FFFF, 11'sd0);
        send_sample(32'd2, 11'sd10);               // timestamp wrap
        send_sample(32'h8000_0000, 11'h2AA);
        send_sample(32'h8000_0001, 11'h555);
        wait_results_done();
    endtask

    task automatic test_register_extremes();
        logic [TIME_W-1:0] dt;
        tx_gaps_on   = 1'b1;
        tx_gap_max   = 40;
        rx_stall_pct = 50;
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: write_all(32'd0, 32'd0, 32'd0, 32'd0);
                1: write_all(32'd1023, '1, '1, '1);
                2: write_all(32'hFFFF_FC05, '1, 32'd0, '1);   // upper bits dropped
                3: write_all(32'd1023, 32'd0, '1, 32'd0);
                default: write_all(CFG_DATA_W'(SETPOINT_RST), PROP_GAIN_RST,
                                   INTEG_GAIN_RST, DERIV_GAIN_RST);
            endcase
            send_sample(pid_prev_time + 32'd1, -11'sd1024);
            send_sample(pid_prev_time, 11'sd1023);
            send_sample(pid_prev_time + DT_MAX, 11'sd0);
            dt = $urandom_range(1, 50);
            send_sample(pid_prev_time + dt, LEVEL_W'($urandom_range(0, 2047)));
            wait_results_done();
        end
    endtask

    task automatic test_random_samples();
        logic [TIME_W-1:0] dt;
        int                lv;
        for (int ph = 0; ph < 5; ph++) begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            tx_gap_max = $urandom_range(2, 80);
            case ($urandom_range(0, 2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 25;
                default: rx_stall_pct = 60;
            endcase
            steer_integral(0);
            wait_results_done();
            if (ph == 4) begin
                write_all($urandom, $urandom, $urandom, $urandom);
            end else begin
                write_all($urandom_range(0, 1023), $urandom_range(0, 32'h1000_0000),
                          $urandom_range(0, 2000), $urandom_range(0, 32'h1000_0000));
            end
            for (int n = 0; n < 40; n++) begin
                case ($urandom_range(0, 19))
                    0:       dt = '0;
                    1:       dt = $urandom;
                    default: dt = $urandom_range(1, 400);
                endcase
                if ($urandom_range(0, 4) == 0) begin
                    lv = int'($urandom_range(0, 2047)) - 1024;
                end else begin
                    lv = int'(reg_setpoint) + int'($urandom_range(0, 16)) - 8;
                    if (lv > 1023) lv = 1023;
                end
                send_sample(pid_prev_time + dt, lv[LEVEL_W-1:0]);
            end
            wait_results_done();
        end
    endtask

    task automatic test_output_backpressure();
        logic [TIME_W-1:0] dt;
        tx_gaps_on   = 1'b0;
        rx_stall_pct = 0;
        rx_hold_go   = 1'b1;
        // results pile up while the receiver holds off; input must stall
        for (int n = 0; n < 12; n++) begin
            dt = $urandom_range(1, 50);
            send_sample(pid_prev_time + dt, LEVEL_W'($urandom_range(0, 2047)));
        end
        wait_results_done();
    endtask

    task automatic test_integral_saturation();
        tx_gaps_on   = 1'b0;
        rx_stall_pct = 10;
        // ki = 1 makes the integral directly visible once it is near 2^30..2^32
        write_all(32'd1023, 32'd0, 32'd1, 32'd0);
        repeat (20) send_sample(pid_prev_time + DT_MAX, -11'sd1024);
        wait_results_done();
        steer_integral(64'sd1_500_000_000);
        repeat (5) send_sample(pid_prev_time + 32'd1_000_000, 11'sd12);
        wait_results_done();
        write_reg(REG_SETPOINT, 32'd0);
        repeat (36) send_sample(pid_prev_time + DT_MAX, 11'sd1023);
        wait_results_done();
        steer_integral(64'sd1_500_000_000);
        repeat (5) send_sample(pid_prev_time + 32'd1_000_000, 11'sd12);
        wait_results_done();
    endtask

    // receiver: random ready runs, or one long hold-off on request
    initial begin : rx_pattern
        int run;
        bit rdy;
        run = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_go) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_go = 1'b0;
                run = 0;
            end else begin
                if (run == 0) begin
                    rdy = ($urandom_range(0, 99) >= rx_stall_pct);
                    run = $urandom_range(1, 12);
                    m_ready <= rdy;
                end
                run--;
            end
        end
    end

    // a result transfer happens at the rising edge after this sample point
    always @(negedge aclk) begin : duty_check
        logic [DUTY_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_duty.size() == 0) begin
                n_errors++;
                $display("%0t: duty %0d with no sample pending", $time, m_pwm_duty);
            end else begin
                want = expected_duty.pop_front();
                if (m_pwm_duty !== want) begin
                    n_errors++;
                    $display("%0t: pwm_duty mismatch, expected %0d, actual %0d",
                             $time, want, m_pwm_duty);
                end
            end
        end
    end

    initial begin : main
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_first_sample();
        test_field_extremes();
        test_register_extremes();
        test_random_samples();
        test_output_backpressure();
        test_integral_saturation();
        wait_results_done();
        repeat (60) @(posedge aclk);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
